[design/arm64_data_processing_immediate_defines.svh]
// Assertion macros, clocked on the rising edge, disabled while reset is low.
`ifndef ARM64_DATA_PROCESSING_IMMEDIATE_DEFINES_SVH
`define ARM64_DATA_PROCESSING_IMMEDIATE_DEFINES_SVH

// Same-cycle implication.
`define ADPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ADPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/adpi_pkg.sv]
`timescale 1ns / 1ps

package adpi_pkg;

    localparam int unsigned XLEN     = 64;
    localparam int unsigned WLEN     = 32;
    localparam int unsigned NUM_REGS = 31;
    localparam logic [4:0]  ZERO_REG = 5'd31;

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_ADDS = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_SUBS = 3'd3,
        ACT_MOVN = 3'd4,
        ACT_MOVZ = 3'd5,
        ACT_MOVK = 3'd6
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic        sf;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [23:0] op2;
        logic [1:0]  hw;
        logic [15:0] imm16;
    } t_in_item;

    typedef struct packed {
        logic            en;
        logic [4:0]      addr;
        logic [XLEN-1:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic       en;
        logic [3:0] nzcv;
    } t_flag_wr;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            wrote;
        logic [3:0]      nzcv;
        t_rf_wr          rf_wr;
        t_flag_wr        flag_wr;
    } t_exec;

endpackage

[design/adpi_intf.sv]
`timescale 1ns / 1ps

interface adpi_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        sf;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [23:0] op2;
    logic [1:0]  hw;
    logic [15:0] imm16;

    modport source (output valid, action, sf, rd, rn, op2, hw, imm16, input ready);
    modport sink   (input valid, action, sf, rd, rn, op2, hw, imm16, output ready);
endinterface

interface adpi_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        wrote;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;

    modport source (output valid, value, wrote, flag_n, flag_z, flag_c, flag_v, input ready);
    modport sink   (input valid, value, wrote, flag_n, flag_z, flag_c, flag_v, output ready);
endinterface

[design/adpi_regfile.sv]
`timescale 1ns / 1ps

module adpi_regfile (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [4:0]                i_rd_addr,
    output logic [adpi_pkg::XLEN-1:0] o_rd_data,
    output logic [3:0]                o_nzcv,
    input  adpi_pkg::t_rf_wr          i_rf_wr,
    input  adpi_pkg::t_flag_wr        i_flag_wr
);

    logic [adpi_pkg::XLEN-1:0] r_regs [adpi_pkg::NUM_REGS];
    logic [3:0]                r_nzcv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < adpi_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_nzcv <= '0;
        end else begin
            if (i_rf_wr.en && i_rf_wr.addr != adpi_pkg::ZERO_REG) begin
                r_regs[i_rf_wr.addr] <= i_rf_wr.data;
            end
            if (i_flag_wr.en) begin
                r_nzcv <= i_flag_wr.nzcv;
            end
        end
    end

    assign o_rd_data = (i_rd_addr == adpi_pkg::ZERO_REG) ? '0 : r_regs[i_rd_addr];
    assign o_nzcv    = r_nzcv;

endmodule

[design/adpi_alu.sv]
`timescale 1ns / 1ps

module adpi_alu (
    input  adpi_pkg::t_in_item        i_item,
    input  logic [adpi_pkg::XLEN-1:0] i_src,
    input  logic [3:0]                i_nzcv,
    output adpi_pkg::t_exec           o_exec
);

    logic [adpi_pkg::XLEN-1:0] mask;
    logic [adpi_pkg::XLEN-1:0] a;
    logic [adpi_pkg::XLEN-1:0] b;
    logic [adpi_pkg::XLEN:0]   sum;
    logic [adpi_pkg::XLEN:0]   diff;
    logic [5:0]                shamt;
    logic [adpi_pkg::XLEN-1:0] placed;
    logic [adpi_pkg::XLEN-1:0] hmask;
    logic [adpi_pkg::XLEN-1:0] res;
    logic [adpi_pkg::XLEN-1:0] ovf;
    logic                      valid;
    logic                      sets;
    logic                      fn;
    logic                      fz;
    logic                      fc;
    logic                      fv;

    always_comb begin
        mask   = i_item.sf ? '1 : {{(adpi_pkg::XLEN-adpi_pkg::WLEN){1'b0}},
                                   {adpi_pkg::WLEN{1'b1}}};
        a      = i_src & mask;
        b      = {{(adpi_pkg::XLEN-24){1'b0}}, i_item.op2} & mask;
        sum    = {1'b0, a} + {1'b0, b};
        diff   = {1'b0, a} - {1'b0, b};
        shamt  = {i_item.hw, 4'b0000};
        placed = {{(adpi_pkg::XLEN-16){1'b0}}, i_item.imm16} << shamt;
        hmask  = {{(adpi_pkg::XLEN-16){1'b0}}, 16'hFFFF} << shamt;
        res    = '0;
        ovf    = '0;
        valid  = 1'b1;
        sets   = 1'b0;
        fc     = 1'b0;

        case (adpi_pkg::t_action'(i_item.action))
            adpi_pkg::ACT_ADD, adpi_pkg::ACT_ADDS: begin
                res  = sum[adpi_pkg::XLEN-1:0] & mask;
                fc   = i_item.sf ? sum[adpi_pkg::XLEN] : sum[adpi_pkg::WLEN];
                ovf  = (a ^ res) & (b ^ res);
                sets = i_item.action[0];
            end
            adpi_pkg::ACT_SUB, adpi_pkg::ACT_SUBS: begin
                res  = diff[adpi_pkg::XLEN-1:0] & mask;
                fc   = !diff[adpi_pkg::XLEN];
                ovf  = (a ^ b) & (a ^ res);
                sets = i_item.action[0];
            end
            adpi_pkg::ACT_MOVN: res = ~placed & mask;
            adpi_pkg::ACT_MOVZ: res = placed & mask;
            adpi_pkg::ACT_MOVK: res = ((i_src & ~hmask) | placed) & mask;
            default:            valid = 1'b0;
        endcase

        fn = i_item.sf ? res[adpi_pkg::XLEN-1] : res[adpi_pkg::WLEN-1];
        fv = i_item.sf ? ovf[adpi_pkg::XLEN-1] : ovf[adpi_pkg::WLEN-1];
        fz = (res == '0);

        o_exec.value        = res;
        o_exec.wrote        = valid && (i_item.rd != adpi_pkg::ZERO_REG);
        o_exec.rf_wr.en     = o_exec.wrote;
        o_exec.rf_wr.addr   = i_item.rd;
        o_exec.rf_wr.data   = res;
        o_exec.flag_wr.en   = sets;
        o_exec.flag_wr.nzcv = {fn, fz, fc, fv};
        o_exec.nzcv         = sets ? {fn, fz, fc, fv} : i_nzcv;
    end

endmodule

[design/arm64_data_processing_immediate.sv]
`timescale 1ns / 1ps
// Channel  Side  Beat fields
// i_in     in    action, sf, rd, rn, op2, hw, imm16
// o_out    out   value, wrote, flag_n, flag_z, flag_c, flag_v
//
// One beat in and one beat out per cycle sustained while the output is ready.
// Input register feeds the ALU; register file and NZCV update as the item enters
// the output register, so the next item sees them with no hazard.
// Synchronous reset clears all 31 registers, NZCV and both valid bits at once.
// A stalled output holds its register; input ready drops only while both stages are full.

`include "arm64_data_processing_immediate_defines.svh"

module arm64_data_processing_immediate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    adpi_in_if.sink           i_in,
    adpi_out_if.source        o_out
);

    adpi_pkg::t_in_item        r_in;
    adpi_pkg::t_in_item        n_in;
    logic                      r_in_vld;
    logic                      n_in_vld;
    logic                      r_out_vld;
    logic                      n_out_vld;
    adpi_pkg::t_exec           r_out;
    adpi_pkg::t_exec           n_out;
    logic                      advance;
    logic                      in_fire;
    logic [4:0]                rd_addr;
    logic [adpi_pkg::XLEN-1:0] src;
    logic [3:0]                nzcv;
    adpi_pkg::t_exec           exec;
    adpi_pkg::t_rf_wr          rf_wr;
    adpi_pkg::t_flag_wr        flag_wr;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_fire    = i_in.valid && i_in.ready;

    assign rd_addr = (r_in.action == adpi_pkg::ACT_MOVK) ? r_in.rd : r_in.rn;

    assign rf_wr.en        = advance && exec.rf_wr.en;
    assign rf_wr.addr      = exec.rf_wr.addr;
    assign rf_wr.data      = exec.rf_wr.data;
    assign flag_wr.en      = advance && exec.flag_wr.en;
    assign flag_wr.nzcv    = exec.flag_wr.nzcv;

    adpi_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (src),
        .o_nzcv    (nzcv),
        .i_rf_wr   (rf_wr),
        .i_flag_wr (flag_wr)
    );

    adpi_alu u_alu (
        .i_item (r_in),
        .i_src  (src),
        .i_nzcv (nzcv),
        .o_exec (exec)
    );

    always_comb begin
        n_in.action = i_in.action;
        n_in.sf     = i_in.sf;
        n_in.rd     = i_in.rd;
        n_in.rn     = i_in.rn;
        n_in.op2    = i_in.op2;
        n_in.hw     = i_in.hw;
        n_in.imm16  = i_in.imm16;
        n_in_vld    = in_fire ? 1'b1 : (advance ? 1'b0 : r_in_vld);
        n_out_vld   = advance ? 1'b1 : ((r_out_vld && o_out.ready) ? 1'b0 : r_out_vld);
        n_out       = exec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
        if (in_fire) begin
            r_in <= n_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.value  = r_out.value;
    assign o_out.wrote  = r_out.wrote;
    assign o_out.flag_n = r_out.nzcv[3];
    assign o_out.flag_z = r_out.nzcv[2];
    assign o_out.flag_c = r_out.nzcv[1];
    assign o_out.flag_v = r_out.nzcv[0];

    `ADPI_ASSERT_NOW(a_full_stall_blocks_in, i_clk, i_rst_n, r_in_vld && r_out_vld && !o_out.ready, !i_in.ready)
    `ADPI_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, o_out.valid)
    `ADPI_ASSERT_NEXT(a_flags_hold, i_clk, i_rst_n, !flag_wr.en, $stable(nzcv))

endmodule

[tb/sv/arm64_data_processing_immediate_checker.sv]
`timescale 1ns / 1ps

module arm64_data_processing_immediate_checker
    import adpi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    adpi_in_if   i_in_mon,
    adpi_out_if  i_out_mon,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            wrote;
        logic [3:0]      nzcv;
    } t_writeback;

    logic [XLEN-1:0] gpr [NUM_REGS];
    logic [3:0]      nzcv;
    t_writeback      writeback_q [$];

    function automatic logic [XLEN-1:0] read_gpr(input logic [4:0] n);
        return (n == ZERO_REG) ? '0 : gpr[n];
    endfunction

    task automatic execute_instr(input t_in_item it, output t_writeback wb);
        logic [XLEN-1:0] mask;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] res;
        logic [XLEN-1:0] ovf;
        logic [XLEN-1:0] placed;
        int unsigned     sbit;
        int unsigned     shift;
        logic            c;
        logic            v;
        logic            ok;
        mask   = it.sf ? '1 : {{WLEN{1'b0}}, {WLEN{1'b1}}};
        sbit   = it.sf ? XLEN - 1 : WLEN - 1;
        shift  = it.hw * 16;
        placed = {48'd0, it.imm16} << shift;
        res    = '0;
        ok     = 1'b1;
        case (it.action)
            ACT_ADD, ACT_ADDS, ACT_SUB, ACT_SUBS: begin
                a = read_gpr(it.rn) & mask;
                b = {40'd0, it.op2} & mask;
                if (it.action == ACT_SUB || it.action == ACT_SUBS) begin
                    res = (a - b) & mask;
                    c   = (a >= b);
                    ovf = (a ^ b) & (a ^ res);
                end else begin
                    res = (a + b) & mask;
                    c   = (res < a);
                    ovf = (a ^ res) & (b ^ res);
                end
                v = ovf[sbit];
                if (it.action == ACT_ADDS || it.action == ACT_SUBS)
                    nzcv = {res[sbit], res == '0, c, v};
            end
            ACT_MOVN: res = ~placed & mask;
            ACT_MOVZ: res = placed & mask;
            ACT_MOVK: res = ((read_gpr(it.rd) & ~({48'd0, 16'hFFFF} << shift)) | placed) & mask;
            default:  ok = 1'b0;
        endcase
        wb.value = ok ? res : '0;
        wb.wrote = 1'b0;
        if (ok && it.rd != ZERO_REG) begin
            gpr[it.rd] = res;
            wb.wrote   = 1'b1;
        end
        wb.nzcv = nzcv;
    endtask

    task automatic log_mismatch(input string why, input t_writeback e, input t_writeback g);
        o_mismatches++;
        if (o_mismatches <= REPORT_LIMIT)
            $display("%0t %s: exp value=%h wrote=%b nzcv=%b, got value=%h wrote=%b nzcv=%b",
                     $realtime, why, e.value, e.wrote, e.nzcv, g.value, g.wrote, g.nzcv);
    endtask

    always @(posedge i_clk) begin
        t_in_item   instr;
        t_writeback got;
        t_writeback want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++)
                gpr[i] = '0;
            nzcv = '0;
            writeback_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.value, i_out_mon.wrote,
                        {i_out_mon.flag_n, i_out_mon.flag_z, i_out_mon.flag_c, i_out_mon.flag_v}};
                if (writeback_q.size() == 0) begin
                    log_mismatch("unexpected beat", 'x, got);
                end else begin
                    want = writeback_q.pop_front();
                    if (got.value !== want.value || got.wrote !== want.wrote ||
                        got.nzcv !== want.nzcv)
                        log_mismatch("mismatch", want, got);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                instr = '{i_in_mon.action, i_in_mon.sf, i_in_mon.rd, i_in_mon.rn,
                          i_in_mon.op2, i_in_mon.hw, i_in_mon.imm16};
                execute_instr(instr, want);
                writeback_q.push_back(want);
            end
        end
        o_outstanding = writeback_q.size();
    end

endmodule

[tb/sv/arm64_data_processing_immediate_test.sv]
`timescale 1ns / 1ps

module arm64_data_processing_immediate_test;
    import adpi_pkg::*;

    localparam logic [2:0] ACT_UNUSED     = 3'd7;
    localparam int         PHASE_ITEMS    = 235;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TAIL_CYCLES    = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle;
    int   recv_stall;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles;

    adpi_in_if  in_ch ();
    adpi_out_if out_ch ();

    arm64_data_processing_immediate dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    arm64_data_processing_immediate_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("arm64_data_processing_immediate_test NOT OK");
                $finish;
            end
        end
    end

    function automatic t_in_item mk(input logic [2:0] action, input logic sf,
                                    input logic [4:0] rd, input logic [4:0] rn,
                                    input logic [23:0] op2, input logic [1:0] hw,
                                    input logic [15:0] imm16);
        return '{action, sf, rd, rn, op2, hw, imm16};
    endfunction

    // few live registers so results feed back into later operands
    function automatic logic [4:0] pick_reg();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70)
            return 5'($urandom_range(5));
        if (p < 80)
            return ZERO_REG;
        return 5'($urandom_range(31));
    endfunction

    function automatic t_in_item rand_instr();
        t_in_item it;
        it.action = ($urandom_range(99) < 3) ? ACT_UNUSED : 3'($urandom_range(6));
        it.sf     = 1'($urandom_range(1));
        it.rd     = pick_reg();
        it.rn     = pick_reg();
        case ($urandom_range(3))
            0: it.op2 = 24'($urandom);
            1: it.op2 = {12'd0, 12'($urandom)};
            2: it.op2 = {12'($urandom), 12'd0};
            default: begin
                case ($urandom_range(3))
                    0: it.op2 = 24'd0;
                    1: it.op2 = 24'hFFFFFF;
                    2: it.op2 = 24'd1;
                    default: it.op2 = 24'h000FFF;
                endcase
            end
        endcase
        it.hw = 2'($urandom_range(3));
        case ($urandom_range(7))
            0: it.imm16 = 16'h0000;
            1: it.imm16 = 16'hFFFF;
            2: it.imm16 = 16'h8000;
            default: it.imm16 = 16'($urandom);
        endcase
        return it;
    endfunction

    task automatic push_instr(input t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.action = it.action;
        in_ch.sf     = it.sf;
        in_ch.rd     = it.rd;
        in_ch.rn     = it.rn;
        in_ch.op2    = it.op2;
        in_ch.hw     = it.hw;
        in_ch.imm16  = it.imm16;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int unsigned send_pct [4];
        int unsigned recv_pct [4];
        t_in_item    directed [$];
        send_pct = '{0, 73, 0, 38};
        recv_pct = '{0, 0, 73, 38};
        i_rst_n      = 1'b0;
        quiet_cycles = 0;
        send_idle    = 0;
        recv_stall   = 0;
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_ADD;
        in_ch.sf     = 1'b0;
        in_ch.rd     = '0;
        in_ch.rn     = '0;
        in_ch.op2    = '0;
        in_ch.hw     = '0;
        in_ch.imm16  = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = '{
            mk(ACT_MOVN, 1, 0, 0, 0, 0, 16'h0000),
            mk(ACT_ADDS, 1, 1, 0, 1, 0, 0),
            mk(ACT_SUBS, 1, 2, ZERO_REG, 0, 0, 0),
            mk(ACT_SUBS, 1, ZERO_REG, ZERO_REG, 1, 0, 0),
            mk(ACT_ADD, 1, 3, 0, 24'hFFFFFF, 0, 0),
            mk(ACT_MOVZ, 1, 4, 0, 0, 3, 16'h8000),
            mk(ACT_SUBS, 1, 5, 4, 1, 0, 0),
            mk(ACT_ADDS, 0, 6, 0, 1, 0, 0),
            mk(ACT_MOVZ, 0, 7, 0, 0, 1, 16'h7FFF),
            mk(ACT_MOVK, 0, 7, 0, 0, 0, 16'hFFFF),
            mk(ACT_ADDS, 0, 8, 7, 1, 0, 0),
            mk(ACT_SUBS, 0, 9, 8, 1, 0, 0),
            mk(ACT_MOVK, 1, 0, 0, 0, 2, 16'h1234),
            mk(ACT_MOVZ, 0, 10, 0, 0, 2, 16'hFFFF),
            mk(ACT_MOVN, 0, 11, 0, 0, 3, 16'hFFFF),
            mk(ACT_MOVK, 0, 0, 0, 0, 3, 16'hABCD),
            mk(ACT_MOVK, 1, ZERO_REG, 0, 0, 1, 16'h5A5A),
            mk(ACT_MOVN, 1, ZERO_REG, 0, 0, 0, 16'h0000),
            mk(ACT_UNUSED, 1, 12, 0, 24'hFFFFFF, 3, 16'hFFFF),
            mk(ACT_UNUSED, 0, ZERO_REG, ZERO_REG, 0, 0, 0),
            mk(ACT_SUB, 0, 13, ZERO_REG, 24'hFFFFFF, 0, 0),
            mk(ACT_ADDS, 1, 30, 3, 0, 0, 0),
            mk(ACT_MOVK, 1, 30, 0, 0, 1, 16'hFFFF)
        };
        foreach (directed[i])
            push_instr(directed[i]);

        for (int p = 0; p < 4; p++) begin
            send_idle  = send_pct[p];
            recv_stall = recv_pct[p];
            repeat (PHASE_ITEMS)
                push_instr(rand_instr());
            if (p == 1)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("arm64_data_processing_immediate_test OK");
        else
            $display("arm64_data_processing_immediate_test NOT OK");
        $finish;
    end

endmodule

[arm64_data_processing_immediate.f]
+incdir+design
design/adpi_pkg.sv
design/adpi_intf.sv
design/adpi_regfile.sv
design/adpi_alu.sv
design/arm64_data_processing_immediate.sv
tb/sv/arm64_data_processing_immediate_checker.sv
tb/sv/arm64_data_processing_immediate_test.sv
